/* hw/rtl/polyphonic_voice_allocator_assert.svh */
// Assertion macros shared by the voice allocator RTL.
`ifndef POLYPHONIC_VOICE_ALLOCATOR_ASSERT_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PVA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pva assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PVA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pva assertion failed");

`endif

/* hw/rtl/pva_pkg.sv */
// Shared types, constants and the note frequency function of the voice allocator.
package pva_pkg;

  localparam int VOICES_DEF = 16;
  localparam int KEYS       = 128;
  localparam int KW         = $clog2(KEYS);
  localparam int MAX_NV     = 16;

  typedef enum logic [1:0] {
    K_OFF      = 2'd0,
    K_ASSIGNED = 2'd1,
    K_PENDING  = 2'd2
  } key_state_e;

  typedef enum logic [1:0] {
    V_FREE   = 2'd0,
    V_ACTIVE = 2'd1,
    V_HOLD   = 2'd2
  } voice_state_e;

  typedef enum logic [1:0] {
    KIND_NEW      = 2'd0,
    KIND_RETUNE   = 2'd1,
    KIND_GATE_LOW = 2'd2
  } kind_e;

  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CONTROL  = 4'hB;
  localparam logic [6:0] CC_SUSTAIN  = 7'd64;
  localparam logic [6:0] CC_SOUND_OFF = 7'd120;
  localparam logic [6:0] CC_NOTES_OFF = 7'd123;
  localparam logic [6:0] TOP_NOTE    = 7'd119;

  typedef struct packed {
    key_state_e  st;
    logic [3:0]  voice;
    logic [31:0] ts;
  } key_word_t;

  typedef struct packed {
    logic latch;
    logic rd_n;
    logic rd_old;
    logic rd_scan;
    logic vsel_clr;
    logic vsel_inc;
    logic vsel_from_key;
    logic vsel_from_scan;
    logic vscan_step;
    logic on_pend;
    logic on_wr;
    logic off_hold;
    logic key_n_clr;
    logic scan_clr;
    logic scan_step;
    logic old_clr;
    logic rel_fin;
    logic ao_step;
    logic sus_wr;
  } cmd_t;

  typedef struct packed {
    logic is_on;
    logic is_off;
    logic is_allof;
    logic is_sus_on;
    logic is_sus_off;
    logic key_off;
    logic key_asg;
    logic vact_note;
    logic sustain;
    logic vsel_last;
    logic vsel_hold;
    logic scan_done;
  } sts_t;

  // Semitone steps of A, scaled by 2^15.
  localparam logic [24:0] SEMI [12] = '{
    25'd14417920, 25'd15275254, 25'd16183568, 25'd17145893,
    25'd18165441, 25'd19245614, 25'd20390018, 25'd21602472,
    25'd22887021, 25'd24247954, 25'd25689813, 25'd27217409
  };

  // Q13.11 frequency of a MIDI note; notes above the top one give 0.5 Hz.
  function automatic logic [23:0] note_freq(logic [6:0] n);
    logic [6:0]  m;
    logic [3:0]  oct;
    logic [6:0]  k;
    logic [3:0]  s;
    logic [24:0] half;
    logic [24:0] sum;
    logic [23:0] res;
    m   = n + 7'd3;
    oct = 4'd0;
    for (int i = 1; i <= 10; i++) begin
      if (int'(m) >= 12 * i) oct = oct + 4'd1;
    end
    k    = m - 7'(12 * int'(oct));
    s    = 4'd10 - oct;
    half = (s == 4'd0) ? 25'd0 : (25'd1 << (s - 4'd1));
    sum  = SEMI[k[3:0]] + half;
    res  = 24'(sum >> s);
    if (n > TOP_NOTE) res = 24'd1024;
    return res;
  endfunction

endpackage

/* hw/rtl/pva_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/pva_ctrl.sv */
// Sequencer of the voice allocator: walks each message through its steps.
module pva_ctrl
  import pva_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_DECODE    = 16'h0002,
    S_ON_CHK    = 16'h0004,
    S_VSCAN     = 16'h0008,
    S_VPICK     = 16'h0010,
    S_ON_OLDRD  = 16'h0020,
    S_ON_OLDCHK = 16'h0040,
    S_ON_WR     = 16'h0080,
    S_OFF_CHK   = 16'h0100,
    S_OFF_VCHK  = 16'h0200,
    S_REL_SCAN  = 16'h0400,
    S_REL_OLDRD = 16'h0800,
    S_REL_OLDCK = 16'h1000,
    S_REL_FIN   = 16'h2000,
    S_SUS_SCAN  = 16'h4000,
    S_AO        = 16'h8000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts_i.is_on || sts_i.is_off) begin
          cmd_o.rd_n = 1'b1;
          state_d    = sts_i.is_on ? S_ON_CHK : S_OFF_CHK;
        end else if (sts_i.is_allof) begin
          cmd_o.vsel_clr = 1'b1;
          state_d        = S_AO;
        end else if (sts_i.is_sus_on) begin
          cmd_o.sus_wr = 1'b1;
          state_d      = S_IDLE;
        end else if (sts_i.is_sus_off) begin
          cmd_o.sus_wr   = 1'b1;
          cmd_o.vsel_clr = 1'b1;
          state_d        = S_SUS_SCAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_ON_CHK: begin
        // drop a repeated note-on
        if (sts_i.key_off) begin
          cmd_o.vsel_clr = 1'b1;
          state_d        = S_VSCAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_VSCAN: begin
        cmd_o.vscan_step = 1'b1;
        if (sts_i.vsel_last) state_d = S_VPICK;
        else                 cmd_o.vsel_inc = 1'b1;
      end
      S_VPICK: begin
        cmd_o.vsel_from_scan = 1'b1;
        state_d              = S_ON_OLDRD;
      end
      S_ON_OLDRD: begin
        cmd_o.rd_old = 1'b1;
        state_d      = S_ON_OLDCHK;
      end
      S_ON_OLDCHK: begin
        cmd_o.on_pend = 1'b1;
        state_d       = S_ON_WR;
      end
      S_ON_WR: begin
        cmd_o.on_wr = 1'b1;
        state_d     = S_IDLE;
      end
      S_OFF_CHK: begin
        if (sts_i.key_asg) begin
          cmd_o.vsel_from_key = 1'b1;
          state_d             = S_OFF_VCHK;
        end else begin
          cmd_o.key_n_clr = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_OFF_VCHK: begin
        priority if (sts_i.vact_note && sts_i.sustain) begin
          cmd_o.off_hold  = 1'b1;
          cmd_o.key_n_clr = 1'b1;
          state_d         = S_IDLE;
        end else if (sts_i.vact_note) begin
          cmd_o.scan_clr = 1'b1;
          state_d        = S_REL_SCAN;
        end else begin
          cmd_o.key_n_clr = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_REL_SCAN: begin
        // the RAM registers the last key's data behind its read: step once more to weigh it
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_REL_OLDRD;
        end else begin
          cmd_o.rd_scan = 1'b1;
        end
      end
      S_REL_OLDRD: begin
        cmd_o.rd_old = 1'b1;
        state_d      = S_REL_OLDCK;
      end
      S_REL_OLDCK: begin
        cmd_o.old_clr = 1'b1;
        state_d       = S_REL_FIN;
      end
      S_REL_FIN: begin
        cmd_o.rel_fin = 1'b1;
        priority if (sts_i.is_off) begin
          cmd_o.key_n_clr = 1'b1;
          state_d         = S_IDLE;
        end else if (sts_i.vsel_last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.vsel_inc = 1'b1;
          state_d        = S_SUS_SCAN;
        end
      end
      S_SUS_SCAN: begin
        priority if (sts_i.vsel_hold) begin
          cmd_o.scan_clr = 1'b1;
          state_d        = S_REL_SCAN;
        end else if (sts_i.vsel_last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.vsel_inc = 1'b1;
        end
      end
      S_AO: begin
        cmd_o.ao_step = 1'b1;
        if (sts_i.vsel_last) state_d = S_IDLE;
        else                 cmd_o.vsel_inc = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/pva_dp.sv */
// Datapath of the voice allocator: key table, voice registers, scans and result register.
module pva_dp
  import pva_pkg::*;
#(
  parameter int VOICES = VOICES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [7:0]  status_byte_i,
  input  logic [6:0]  data_first_i,
  input  logic [6:0]  data_second_i,
  input  logic [1:0]  message_length_i,
  input  logic [31:0] event_time_i,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  output logic        result_valid_o,
  output logic [3:0]  voice_index_o,
  output logic [1:0]  update_kind_o,
  output logic [23:0] frequency_o,
  output logic [6:0]  velocity_o,
  output logic [31:0] change_time_o,
  output logic        last_o
);

  localparam int NV = (VOICES < MAX_NV) ? VOICES : MAX_NV;
  localparam int VW = (NV > 1) ? $clog2(NV) : 1;

  // message beat
  logic [7:0]  st_q;
  logic [6:0]  d1_q, d2_q;
  logic [1:0]  len_q;
  logic [31:0] t_q;

  logic [4:0]  vcount_q;
  logic        sus_q;

  voice_state_e vstat_q [NV];
  logic [6:0]   vnote_q [NV];
  logic [31:0]  vtime_q [NV];

  logic [VW-1:0] vsel_q;
  logic [VW-1:0] cm1;
  logic          found_q;
  logic [VW-1:0] freev_q, minv_q;
  logic [31:0]   mint_q;

  logic [KEYS-1:0] kvalid_q, kvalid_d;
  logic            rvalid_q;
  logic [KW:0]     kc_q;
  logic [KW-1:0]   kprev;
  logic            have_q;
  logic [KW-1:0]   best_q;
  logic [31:0]     bestt_q;

  logic [KW-1:0] raddr, waddr, clr_idx;
  logic          we, clr_en;
  key_word_t     wdata, rdata;
  logic [$bits(key_word_t)-1:0] rdata_raw;

  logic          key_mine, hold_after, len_ok;
  logic [6:0]    fsrc;
  logic [23:0]   fcalc;

  logic          res_valid_q, res_last_q;
  logic [3:0]    res_voice_q;
  kind_e         res_kind_q;
  logic [23:0]   res_freq_q;
  logic [6:0]    res_vel_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      st_q  <= status_byte_i;
      d1_q  <= data_first_i;
      d2_q  <= data_second_i;
      len_q <= message_length_i;
      t_q   <= event_time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= 5'd16;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  // saturate the voice count to 1..NV, held as count minus one
  always_comb begin
    priority if (vcount_q == 5'd0)      cm1 = '0;
    else if (vcount_q > 5'(NV))         cm1 = VW'(NV - 1);
    else                                cm1 = VW'(vcount_q - 5'd1);
  end

  assign len_ok = (len_q == 2'd3);

  always_comb begin
    sts_o            = '0;
    sts_o.is_on      = len_ok && st_q[7:4] == ST_NOTE_ON && d2_q != 7'd0;
    sts_o.is_off     = len_ok && (st_q[7:4] == ST_NOTE_OFF ||
                                  (st_q[7:4] == ST_NOTE_ON && d2_q == 7'd0));
    sts_o.is_allof   = len_ok && st_q[7:4] == ST_CONTROL &&
                       (d1_q == CC_SOUND_OFF || d1_q == CC_NOTES_OFF);
    sts_o.is_sus_on  = len_ok && st_q[7:4] == ST_CONTROL && d1_q == CC_SUSTAIN && d2_q[6];
    sts_o.is_sus_off = len_ok && st_q[7:4] == ST_CONTROL && d1_q == CC_SUSTAIN && !d2_q[6];
    sts_o.key_off    = !rvalid_q || rdata.st == K_OFF;
    sts_o.key_asg    = rvalid_q && rdata.st == K_ASSIGNED;
    sts_o.vact_note  = vstat_q[vsel_q] == V_ACTIVE && vnote_q[vsel_q] == d1_q;
    sts_o.sustain    = sus_q;
    sts_o.vsel_last  = vsel_q == cm1;
    sts_o.vsel_hold  = vstat_q[vsel_q] == V_HOLD;
    sts_o.scan_done  = kc_q[KW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sus_q <= 1'b0;
    end else if (cmd_i.sus_wr) begin
      sus_q <= sts_o.is_sus_on;
    end
  end

  // key table: entry with a clear valid bit reads as off
  assign rdata    = key_word_t'(rdata_raw);
  assign key_mine = rvalid_q && rdata.st == K_ASSIGNED && rdata.voice == 4'(vsel_q);

  always_comb begin
    priority if (cmd_i.rd_n) raddr = d1_q;
    else if (cmd_i.rd_old)   raddr = vnote_q[vsel_q];
    else if (cmd_i.rd_scan)  raddr = kc_q[KW-1:0];
    else                     raddr = '0;
  end

  always_comb begin
    we    = 1'b0;
    waddr = d1_q;
    wdata = '{st: K_ASSIGNED, voice: 4'(vsel_q), ts: t_q};
    priority if (cmd_i.on_pend) begin
      we    = vstat_q[vsel_q] == V_ACTIVE && key_mine;
      waddr = vnote_q[vsel_q];
      wdata = '{st: K_PENDING, voice: rdata.voice, ts: rdata.ts};
    end else if (cmd_i.on_wr) begin
      we = 1'b1;
    end else if (cmd_i.rel_fin) begin
      we    = have_q;
      waddr = best_q;
      wdata = '{st: K_ASSIGNED, voice: 4'(vsel_q), ts: bestt_q};
    end else begin
      we = 1'b0;
    end
  end

  always_comb begin
    clr_en  = 1'b0;
    clr_idx = d1_q;
    priority if (cmd_i.key_n_clr) begin
      clr_en = 1'b1;
    end else if (cmd_i.old_clr) begin
      clr_en  = key_mine;
      clr_idx = vnote_q[vsel_q];
    end else begin
      clr_en = 1'b0;
    end
  end

  always_comb begin
    kvalid_d = kvalid_q;
    if (clr_en) kvalid_d[clr_idx] = 1'b0;
    if (we)     kvalid_d[waddr]   = 1'b1;
    if (cmd_i.ao_step) kvalid_d   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kvalid_q <= '0;
      rvalid_q <= 1'b0;
    end else begin
      kvalid_q <= kvalid_d;
      rvalid_q <= kvalid_q[raddr];
    end
  end

  pva_ram #(
    .WIDTH ($bits(key_word_t)),
    .DEPTH (KEYS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  // newest pending key: one key a beat, with the read data registered behind the address
  assign kprev = kc_q[KW-1:0] - KW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kc_q   <= '0;
      have_q <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      kc_q   <= '0;
      have_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      kc_q <= kc_q + (KW+1)'(1);
      if (kc_q != '0 && rvalid_q && rdata.st == K_PENDING &&
          (!have_q || rdata.ts > bestt_q)) begin
        have_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && kc_q != '0 && rvalid_q && rdata.st == K_PENDING &&
        (!have_q || rdata.ts > bestt_q)) begin
      best_q  <= kprev;
      bestt_q <= rdata.ts;
    end
  end

  // voice select and first-free / oldest tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsel_q  <= '0;
      found_q <= 1'b0;
    end else begin
      priority if (cmd_i.vsel_clr) begin
        vsel_q  <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.vsel_inc) begin
        vsel_q <= vsel_q + VW'(1);
      end else if (cmd_i.vsel_from_key) begin
        vsel_q <= rdata.voice[VW-1:0];
      end else if (cmd_i.vsel_from_scan) begin
        vsel_q <= found_q ? freev_q : minv_q;
      end else begin
        vsel_q <= vsel_q;
      end
      if (cmd_i.vscan_step && vstat_q[vsel_q] == V_FREE && !found_q) found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.vscan_step) begin
      if (vstat_q[vsel_q] == V_FREE && !found_q) freev_q <= vsel_q;
      if (vsel_q == '0 || vtime_q[vsel_q] < mint_q) begin
        minv_q <= vsel_q;
        mint_q <= vtime_q[vsel_q];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NV; i++) begin
        vstat_q[i] <= V_FREE;
        vnote_q[i] <= '0;
        vtime_q[i] <= '0;
      end
    end else begin
      priority if (cmd_i.on_wr) begin
        vstat_q[vsel_q] <= V_ACTIVE;
        vnote_q[vsel_q] <= d1_q;
        vtime_q[vsel_q] <= t_q;
      end else if (cmd_i.off_hold) begin
        vstat_q[vsel_q] <= V_HOLD;
      end else if (cmd_i.rel_fin) begin
        vstat_q[vsel_q] <= have_q ? V_ACTIVE : V_FREE;
        if (have_q) vnote_q[vsel_q] <= best_q;
      end else if (cmd_i.ao_step) begin
        vstat_q[vsel_q] <= V_FREE;
      end else begin
        vstat_q[vsel_q] <= vstat_q[vsel_q];
      end
    end
  end

  // another holding voice further up means this release is not the final beat
  always_comb begin
    hold_after = 1'b0;
    for (int j = 0; j < NV; j++) begin
      if (vstat_q[j] == V_HOLD && j > int'(vsel_q) && j <= int'(cm1)) hold_after = 1'b1;
    end
  end

  assign fsrc  = cmd_i.rel_fin ? best_q : d1_q;
  assign fcalc = note_freq(fsrc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_q <= 1'b0;
    else         res_valid_q <= cmd_i.on_wr || cmd_i.rel_fin || cmd_i.ao_step;
  end

  always_ff @(posedge clk_i) begin
    res_voice_q <= 4'(vsel_q);
    priority if (cmd_i.on_wr) begin
      res_kind_q <= KIND_NEW;
      res_freq_q <= fcalc;
      res_vel_q  <= d2_q;
      res_last_q <= 1'b1;
    end else if (cmd_i.rel_fin) begin
      res_kind_q <= have_q ? KIND_RETUNE : KIND_GATE_LOW;
      res_freq_q <= have_q ? fcalc : 24'd0;
      res_vel_q  <= '0;
      res_last_q <= sts_o.is_off || !hold_after;
    end else begin
      res_kind_q <= KIND_GATE_LOW;
      res_freq_q <= '0;
      res_vel_q  <= '0;
      res_last_q <= sts_o.vsel_last;
    end
  end

  assign result_valid_o = res_valid_q;
  assign voice_index_o  = res_voice_q;
  assign update_kind_o  = res_kind_q;
  assign frequency_o    = res_freq_q;
  assign velocity_o     = res_vel_q;
  assign change_time_o  = t_q;
  assign last_o         = res_last_q;

endmodule

/* hw/rtl/polyphonic_voice_allocator.sv */
// Polyphonic voice allocator: MIDI note messages to voice updates, oldest voice stolen.
// A note-on scans the voices in use; a note-off with release scans the 128-entry key table
// at one key a cycle for the newest pending key; all-notes-off gives one beat a voice.
// Sustain release scans the key table once per holding voice. One message at a time.
// Results are one-cycle strobes the receiver cannot stall.
// Reset clears all keys (valid bits), all voices to free, sustain off, voice count to 16.
`include "polyphonic_voice_allocator_assert.svh"

module polyphonic_voice_allocator
  import pva_pkg::*;
#(
  parameter int VOICES = VOICES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // message beat
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  status_byte_i,
  input  logic [6:0]  data_first_i,
  input  logic [6:0]  data_second_i,
  input  logic [1:0]  message_length_i,
  input  logic [31:0] event_time_i,
  // voice count register
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  // result beats
  output logic        result_valid_o,
  output logic [3:0]  voice_index_o,
  output logic [1:0]  update_kind_o,
  output logic [23:0] frequency_o,
  output logic [6:0]  velocity_o,
  output logic [31:0] change_time_o,
  output logic        last_o
);

  localparam int NV = (VOICES < MAX_NV) ? VOICES : MAX_NV;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: decides the step order of each message.
  pva_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Datapath: key table RAM, voice state, scans and the result register.
  pva_dp #(
    .VOICES (VOICES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .status_byte_i    (status_byte_i),
    .data_first_i     (data_first_i),
    .data_second_i    (data_second_i),
    .message_length_i (message_length_i),
    .event_time_i     (event_time_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .result_valid_o   (result_valid_o),
    .voice_index_o    (voice_index_o),
    .update_kind_o    (update_kind_o),
    .frequency_o      (frequency_o),
    .velocity_o       (velocity_o),
    .change_time_o    (change_time_o),
    .last_o           (last_o)
  );

  // An accepted message always occupies the sequencer in the next cycle.
  `PVA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // Results only come from a message in progress.
  `PVA_ASSERT_IMPL(a_result_busy, result_valid_o, $past(busy))
  // Reported voice indices never exceed NV minus one.
  `PVA_ASSERT_IMPL(a_voice_range, result_valid_o, voice_index_o <= 4'(NV - 1))
  // A gate-low beat carries no frequency and no velocity.
  `PVA_ASSERT_IMPL(a_gate_low_zero, result_valid_o && update_kind_o == KIND_GATE_LOW,
                   frequency_o == '0 && velocity_o == '0)

endmodule

/* tb/tb_polyphonic_voice_allocator.sv */
// Self-checking testbench of the polyphonic voice allocator: directed and random MIDI beats.
module tb_polyphonic_voice_allocator;
  import pva_pkg::*;

  localparam int NV        = 16;
  localparam int IDLE_MAX  = 20000;  // cycles with no accepted beat before giving up
  localparam int SETTLE    = 3000;   // covers a sustain release of every voice

  typedef struct packed {
    logic [3:0]  voice;
    kind_e       kind;
    logic [23:0] freq;
    logic [6:0]  vel;
    logic [31:0] t;
    logic        last;
  } voice_update_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  status_byte_i = '0;
  logic [6:0]  data_first_i = '0;
  logic [6:0]  data_second_i = '0;
  logic [1:0]  message_length_i = '0;
  logic [31:0] event_time_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        result_valid_o;
  logic [3:0]  voice_index_o;
  logic [1:0]  update_kind_o;
  logic [23:0] frequency_o;
  logic [6:0]  velocity_o;
  logic [31:0] change_time_o;
  logic        last_o;

  polyphonic_voice_allocator uut (
    .clk_i, .rst_ni, .start, .busy,
    .status_byte_i, .data_first_i, .data_second_i, .message_length_i, .event_time_i,
    .cfg_we_i, .cfg_wdata_i,
    .result_valid_o, .voice_index_o, .update_kind_o, .frequency_o, .velocity_o,
    .change_time_o, .last_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Predictor state: a mirror of the key and voice tables.
  key_state_e   key_st   [KEYS];
  logic [3:0]   key_vc   [KEYS];
  logic [31:0]  key_ts   [KEYS];
  voice_state_e vc_st    [NV];
  logic [6:0]   vc_note  [NV];
  logic [31:0]  vc_ts    [NV];
  logic         pedal_down;
  logic [4:0]   voice_count;

  voice_update_t pending_updates[$];
  voice_update_t step_updates[$];
  int errors = 0;
  int idle_cycles = 0;
  int sender_idle = 0;       // percent
  logic [31:0] clock_frames = 0;

  localparam logic [24:0] SEMI_STEP [12] = '{
    25'd14417920, 25'd15275254, 25'd16183568, 25'd17145893,
    25'd18165441, 25'd19245614, 25'd20390018, 25'd21602472,
    25'd22887021, 25'd24247954, 25'd25689813, 25'd27217409
  };

  function automatic logic [23:0] pitch_hz(int n);
    int m, s;
    logic [31:0] half;
    if (n > 119) return 24'd1024;
    m = n + 3;
    s = 10 - m / 12;
    half = (s > 0) ? (32'd1 << (s - 1)) : 32'd0;
    return 24'((32'(SEMI_STEP[m % 12]) + half) >> s);
  endfunction

  function automatic int voices_in_use();
    if (voice_count < 1) return 1;
    if (voice_count > NV) return NV;
    return voice_count;
  endfunction

  function automatic void push_update(int v, kind_e k, logic [23:0] f, logic [6:0] vel,
                                      logic [31:0] t);
    voice_update_t u;
    u = '{voice: 4'(v), kind: k, freq: f, vel: vel, t: t, last: 1'b0};
    step_updates.push_back(u);
  endfunction

  // Retune a freed voice to the newest pending key, or drop its gate.
  function automatic void retire_voice(int v, logic [31:0] t);
    int newest;
    int old;
    newest = -1;
    old = vc_note[v];
    for (int i = 0; i < KEYS; i++)
      if (key_st[i] == K_PENDING && (newest < 0 || key_ts[i] > key_ts[newest])) newest = i;
    if (key_st[old] == K_ASSIGNED && key_vc[old] == 4'(v)) key_st[old] = K_OFF;
    if (newest >= 0) begin
      key_st[newest] = K_ASSIGNED;
      key_vc[newest] = 4'(v);
      vc_note[v] = 7'(newest);
      vc_st[v] = V_ACTIVE;
      push_update(v, KIND_RETUNE, pitch_hz(newest), 7'd0, t);
    end else begin
      vc_st[v] = V_FREE;
      push_update(v, KIND_GATE_LOW, 24'd0, 7'd0, t);
    end
  endfunction

  function automatic void key_down(int n, logic [6:0] vel, logic [31:0] t);
    int c, v, old;
    bit found;
    c = voices_in_use();
    v = 0;
    found = 0;
    if (key_st[n] != K_OFF) return;
    for (int i = 0; i < c && !found; i++)
      if (vc_st[i] == V_FREE) begin
        v = i;
        found = 1;
      end
    if (!found) begin
      v = 0;
      for (int i = 1; i < c; i++) if (vc_ts[i] < vc_ts[v]) v = i;
    end
    if (vc_st[v] == V_ACTIVE) begin
      old = vc_note[v];
      if (key_st[old] == K_ASSIGNED && key_vc[old] == 4'(v)) key_st[old] = K_PENDING;
    end
    key_st[n] = K_ASSIGNED;
    key_vc[n] = 4'(v);
    key_ts[n] = t;
    vc_st[v] = V_ACTIVE;
    vc_note[v] = 7'(n);
    vc_ts[v] = t;
    push_update(v, KIND_NEW, pitch_hz(n), vel, t);
  endfunction

  function automatic void key_up(int n, logic [31:0] t);
    int v;
    if (key_st[n] == K_ASSIGNED) begin
      v = key_vc[n];
      if (vc_st[v] == V_ACTIVE && vc_note[v] == 7'(n)) begin
        if (pedal_down) vc_st[v] = V_HOLD;
        else retire_voice(v, t);
      end
    end
    key_st[n] = K_OFF;
  endfunction

  // Work out the updates one message causes and queue them for the checker.
  function automatic void predict_message(logic [7:0] sb, logic [6:0] d1, logic [6:0] d2,
                                          logic [1:0] len, logic [31:0] t);
    step_updates.delete();
    if (len == 2'd3) begin
      case (sb[7:4])
        ST_NOTE_ON: begin
          if (d2 == 0) key_up(d1, t);
          else key_down(d1, d2, t);
        end
        ST_NOTE_OFF: key_up(d1, t);
        ST_CONTROL: begin
          if (d1 == CC_SOUND_OFF || d1 == CC_NOTES_OFF) begin
            for (int i = 0; i < voices_in_use(); i++) begin
              vc_st[i] = V_FREE;
              push_update(i, KIND_GATE_LOW, 24'd0, 7'd0, t);
            end
            for (int i = 0; i < KEYS; i++) key_st[i] = K_OFF;
          end else if (d1 == CC_SUSTAIN) begin
            if (d2 > 63) pedal_down = 1'b1;
            else begin
              pedal_down = 1'b0;
              for (int i = 0; i < voices_in_use(); i++)
                if (vc_st[i] == V_HOLD) retire_voice(i, t);
            end
          end
        end
        default: ;
      endcase
    end
    if (step_updates.size() > 0) step_updates[$].last = 1'b1;
    foreach (step_updates[i]) pending_updates.push_back(step_updates[i]);
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp);
    errors++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
  endtask

  // Check every result strobe against the oldest expected update.
  always @(posedge clk_i) begin
    voice_update_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_updates.size() == 0) begin
        report_mismatch("unexpected update, voice", voice_index_o, 0);
      end else begin
        e = pending_updates.pop_front();
        if (voice_index_o !== e.voice) report_mismatch("voice_index", voice_index_o, e.voice);
        if (update_kind_o !== e.kind) report_mismatch("update_kind", update_kind_o, e.kind);
        if (frequency_o !== e.freq) report_mismatch("frequency", frequency_o, e.freq);
        if (velocity_o !== e.vel) report_mismatch("velocity", velocity_o, e.vel);
        if (change_time_o !== e.t) report_mismatch("change_time", change_time_o, e.t);
        if (last_o !== e.last) report_mismatch("last", last_o, e.last);
      end
    end
  end

  // Watchdog on cycles with no accepted beat in either direction.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_MAX) begin
      $display("polyphonic_voice_allocator verification failed");
      $finish;
    end
  end

  // Send one message beat; hold start until accepted and the block is idle again, then drop it.
  task automatic send_message(logic [7:0] sb, logic [6:0] d1, logic [6:0] d2,
                              logic [1:0] len, logic [31:0] t);
    while ($urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    status_byte_i <= sb;
    data_first_i <= d1;
    data_second_i <= d2;
    message_length_i <= len;
    event_time_i <= t;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_message(sb, d1, d2, len, t);
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  // Advance the frame clock so note times grow, with ties now and then.
  function automatic logic [31:0] next_frame();
    if ($urandom_range(9) != 0) clock_frames = clock_frames + $urandom_range(1, 300);
    return clock_frames;
  endfunction

  task automatic drain_updates();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_updates.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_voice_count(logic [4:0] n);
    drain_updates();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    voice_count = n;
  endtask

  task automatic test_directed();
    send_message(8'h90, 7'd0, 7'd127, 2'd3, 32'd0);
    send_message(8'h9F, 7'd127, 7'd1, 2'd3, 32'hFFFF_FFFF);
    send_message(8'h93, 7'd119, 7'd64, 2'd3, 32'd10);
    send_message(8'h93, 7'd119, 7'd64, 2'd3, 32'd11);   // repeated note-on
    send_message(8'h90, 7'd60, 7'd100, 2'd2, 32'd12);   // short message
    send_message(8'h90, 7'd60, 7'd100, 2'd0, 32'd12);
    send_message(8'h80, 7'd0, 7'd0, 2'd3, 32'd20);
    send_message(8'h90, 7'd119, 7'd0, 2'd3, 32'd21);    // velocity zero acts as off
    send_message(8'h85, 7'd55, 7'd3, 2'd3, 32'd22);     // key already off
    send_message(8'hB0, 7'd64, 7'd64, 2'd3, 32'd30);    // sustain on
    send_message(8'h90, 7'd40, 7'd50, 2'd3, 32'd31);
    send_message(8'h80, 7'd40, 7'd0, 2'd3, 32'd32);     // held by sustain
    send_message(8'hB0, 7'd64, 7'd63, 2'd3, 32'd33);    // sustain off releases
    send_message(8'hB0, 7'd7, 7'd127, 2'd3, 32'd34);    // other controller
    send_message(8'hE0, 7'd7, 7'd127, 2'd3, 32'd35);    // other status
    send_message(8'h00, 7'd0, 7'd0, 2'd3, 32'd35);
    send_message(8'hFF, 7'd127, 7'd127, 2'd3, 32'd35);
    send_message(8'hB0, 7'd120, 7'd0, 2'd3, 32'd40);    // all sounds off
    send_message(8'hB0, 7'd123, 7'd0, 2'd3, 32'd41);    // all notes off
    clock_frames = 100;
  endtask

  // Fill every voice, then steal; the stolen keys go pending and return on release.
  task automatic test_stealing(int notes);
    logic [6:0] held[$];
    logic [6:0] n;
    for (int i = 0; i < notes; i++) begin
      n = 7'($urandom_range(127));
      held.push_back(n);
      send_message(8'h90 | 8'($urandom_range(15)), n, 7'($urandom_range(1, 127)), 2'd3,
                   next_frame());
    end
    held.shuffle();
    foreach (held[i])
      send_message(($urandom_range(1)) ? 8'h80 : 8'h90, held[i], 7'd0, 2'd3, next_frame());
  endtask

  // Mostly well-formed play with sustain, with some noise mixed in.
  task automatic test_random_play(int items);
    logic [7:0] sb;
    logic [6:0] d1;
    logic [6:0] d2;
    int pick;
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(99);
      d1 = 7'($urandom_range(127));
      d2 = 7'($urandom_range(127));
      if (pick < 45) begin
        sb = 8'h90 | 8'($urandom_range(15));
        if (d2 == 0) d2 = 7'd1;
        d1 = 7'($urandom_range(40, 80));
      end else if (pick < 75) begin
        sb = 8'h80 | 8'($urandom_range(15));
        d1 = 7'($urandom_range(40, 80));
      end else if (pick < 85) begin
        sb = 8'hB0 | 8'($urandom_range(15));
        d1 = CC_SUSTAIN;
      end else if (pick < 88) begin
        sb = 8'hB0;
        d1 = ($urandom_range(1)) ? CC_SOUND_OFF : CC_NOTES_OFF;
      end else begin
        sb = 8'($urandom_range(255));
      end
      send_message(sb, d1, d2, ($urandom_range(9) == 0) ? 2'($urandom_range(2)) : 2'd3,
                   ($urandom_range(49) == 0) ? $urandom() : next_frame());
    end
  endtask

  // Pause the sender until the block has caught up, then go on.
  task automatic test_quiet_pause();
    send_message(8'h90, 7'd64, 7'd90, 2'd3, next_frame());
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_updates.size() > 0) @(posedge clk_i);
    send_message(8'h80, 7'd64, 7'd0, 2'd3, next_frame());
  endtask

  initial begin
    for (int i = 0; i < KEYS; i++) begin
      key_st[i] = K_OFF;
      key_vc[i] = '0;
      key_ts[i] = '0;
    end
    for (int i = 0; i < NV; i++) begin
      vc_st[i] = V_FREE;
      vc_note[i] = '0;
      vc_ts[i] = '0;
    end
    pedal_down = 1'b0;
    voice_count = 5'd16;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_quiet_pause();
    sender_idle = 58;
    test_stealing(20);
    write_voice_count(5'd1);
    sender_idle = 0;
    test_stealing(6);
    test_random_play(60);
    write_voice_count(5'd0);
    test_random_play(40);
    write_voice_count(5'd31);
    sender_idle = 22;
    test_random_play(60);
    write_voice_count(5'd4);
    sender_idle = 58;
    test_stealing(8);
    test_random_play(70);
    write_voice_count(5'd16);
    sender_idle = 0;
    test_random_play(100);
    test_quiet_pause();
    write_voice_count(5'd9);
    sender_idle = 22;
    test_random_play(60);

    drain_updates();
    if (errors == 0) $display("polyphonic_voice_allocator verification clean");
    else $display("polyphonic_voice_allocator verification failed");
    $finish;
  end

endmodule
